### src/vtp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_pkg
// Widths, types and register codes shared by the vertex transform block.
// ----------------------------------------------------------------------------
package vtp_pkg;

	localparam int COMPONENT_WIDTH = 32;
	localparam int COEF_WIDTH      = 16;

	localparam int FIELD_W     = 32;
	localparam int ROW_W       = 64;
	localparam int COEF_PITCH  = 16;
	localparam int NUM_COMP    = 4;
	localparam int NUM_DIV     = 3;
	localparam int PROD_SHIFT  = 8;
	localparam int FRAC_SHIFT  = 16;
	localparam int COEF_ONE    = 256;
	localparam int CFG_IDX_W   = 3;

	localparam int PROD_W      = COMPONENT_WIDTH + COEF_WIDTH;
	localparam int SUM_W       = PROD_W + 2;
	localparam int NUM_W       = COMPONENT_WIDTH + FRAC_SHIFT;
	// two quotient bits per divider stage
	localparam int DIV_ITERS   = COMPONENT_WIDTH / 2;
	localparam int QUO_W       = 2 * DIV_ITERS;

	localparam int LANE_STAGES = 3;
	localparam int DIV_STAGES  = DIV_ITERS + 3;
	localparam int PIPE_STAGES = LANE_STAGES + DIV_STAGES + 1;

	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;
	typedef logic signed [COEF_WIDTH-1:0]      coef_t;
	typedef logic signed [FIELD_W-1:0]         field_t;

	localparam comp_t COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};
	localparam comp_t COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_DIV_EN = 3'd4
	} cfg_reg_t;

	// undivided components and divide decision, carried beside the dividers
	typedef struct packed {
		comp_t [NUM_COMP-1:0] comp;
		logic                 use_div;
	} pass_t;

endpackage

### src/vtp_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_in_if
// Vertex input channel: valid/ready with four Q16.16 components.
// ----------------------------------------------------------------------------
interface vtp_in_if;
	logic            valid;
	logic            ready;
	vtp_pkg::field_t in_x;
	vtp_pkg::field_t in_y;
	vtp_pkg::field_t in_z;
	vtp_pkg::field_t in_w;

	modport source (output valid, output in_x, output in_y, output in_z, output in_w,
		input ready);
	modport sink (input valid, input in_x, input in_y, input in_z, input in_w,
		output ready);
endinterface

### src/vtp_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_out_if
// Result channel: valid/ready with transformed vertex and divide flag.
// ----------------------------------------------------------------------------
interface vtp_out_if;
	logic            valid;
	logic            ready;
	vtp_pkg::field_t out_x;
	vtp_pkg::field_t out_y;
	vtp_pkg::field_t out_z;
	vtp_pkg::field_t out_w;
	logic            was_divided;

	modport source (output valid, output out_x, output out_y, output out_z, output out_w,
		output was_divided, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z, input out_w,
		input was_divided, output ready);
endinterface

### src/vertex_transform_perspective_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_transform_perspective_core
// 4x4 Q8.8 matrix times Q16.16 vertex with optional divide by w.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    in_x, in_y, in_z, in_w
//   out_ch    out  valid/ready    out_x, out_y, out_z, out_w, was_divided
//   cfg       in   cfg_we         cfg_index, cfg_data
//
// One item per cycle while out_ch does not stall; 3 lane stages, 19 divider
// stages and an output register, with a two-bit-per-stage divider.
// Reset clears all pipeline valid bits, loads the identity matrix, divide off.
// Every stage advances when it is empty or the next one advances, so bubbles
// close up; in_ch.ready drops only when all stages hold items and out_ch stalls.
// ----------------------------------------------------------------------------
module vertex_transform_perspective_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vtp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vtp_pkg::ROW_W-1:0]       cfg_data,
	vtp_in_if.sink                          in_ch,
	vtp_out_if.source                       out_ch
);

	localparam int NP = vtp_pkg::PIPE_STAGES;
	localparam int LS = vtp_pkg::LANE_STAGES;
	localparam int DS = vtp_pkg::DIV_STAGES;

	logic [vtp_pkg::ROW_W-1:0] row_q [vtp_pkg::NUM_COMP];
	logic                      div_en_q;

	logic [NP-1:0]             v_q;
	logic [NP-1:0]             adv;

	vtp_pkg::comp_t            vec [vtp_pkg::NUM_COMP];
	vtp_pkg::comp_t            res [vtp_pkg::NUM_COMP];
	vtp_pkg::comp_t            quo [vtp_pkg::NUM_DIV];
	vtp_pkg::pass_t            pass_s [DS];
	vtp_pkg::comp_t            sel [vtp_pkg::NUM_COMP];

	vtp_pkg::field_t           out_x_q;
	vtp_pkg::field_t           out_y_q;
	vtp_pkg::field_t           out_z_q;
	vtp_pkg::field_t           out_w_q;
	logic                      was_divided_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < vtp_pkg::NUM_COMP; i++) begin
				row_q[i] <= vtp_pkg::ROW_W'(vtp_pkg::COEF_ONE) << (vtp_pkg::COEF_PITCH*i);
			end
			div_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (vtp_pkg::cfg_reg_t'(cfg_index))
				vtp_pkg::REG_ROW0:   row_q[0] <= cfg_data;
				vtp_pkg::REG_ROW1:   row_q[1] <= cfg_data;
				vtp_pkg::REG_ROW2:   row_q[2] <= cfg_data;
				vtp_pkg::REG_ROW3:   row_q[3] <= cfg_data;
				vtp_pkg::REG_DIV_EN: div_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage i may load when any stage from i onward is empty or the output drains
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			adv[i] = out_ch.ready | (|((~v_q) >> i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (adv[0]) begin
				v_q[0] <= in_ch.valid;
			end
			for (int i = 1; i < NP; i++) begin
				if (adv[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_ch.ready = adv[0];

	assign vec[0] = vtp_pkg::COMPONENT_WIDTH'(unsigned'(in_ch.in_x));
	assign vec[1] = vtp_pkg::COMPONENT_WIDTH'(unsigned'(in_ch.in_y));
	assign vec[2] = vtp_pkg::COMPONENT_WIDTH'(unsigned'(in_ch.in_z));
	assign vec[3] = vtp_pkg::COMPONENT_WIDTH'(unsigned'(in_ch.in_w));

	for (genvar r = 0; r < vtp_pkg::NUM_COMP; r++) begin : g_lane
		vtp_lane u_lane (
			.clk (clk),
			.en  (adv[LS-1:0]),
			.row (row_q[r]),
			.vec (vec),
			.res (res[r])
		);
	end

	for (genvar c = 0; c < vtp_pkg::NUM_DIV; c++) begin : g_div
		vtp_div_lane u_div (
			.clk (clk),
			.en  (adv[LS +: DS]),
			.num (res[c]),
			.den (res[vtp_pkg::NUM_COMP-1]),
			.quo (quo[c])
		);
	end

	// undivided values ride alongside the dividers
	always_ff @(posedge clk) begin
		if (adv[LS]) begin
			for (int i = 0; i < vtp_pkg::NUM_COMP; i++) begin
				pass_s[0].comp[i] <= res[i];
			end
			pass_s[0].use_div <= div_en_q && (res[vtp_pkg::NUM_COMP-1] != '0);
		end
	end

	for (genvar s = 1; s < DS; s++) begin : g_pass
		always_ff @(posedge clk) begin
			if (adv[LS+s]) begin
				pass_s[s] <= pass_s[s-1];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < vtp_pkg::NUM_DIV; i++) begin
			sel[i] = pass_s[DS-1].use_div ? quo[i] : pass_s[DS-1].comp[i];
		end
		sel[vtp_pkg::NUM_COMP-1] = pass_s[DS-1].comp[vtp_pkg::NUM_COMP-1];
	end

	always_ff @(posedge clk) begin
		if (adv[NP-1]) begin
			out_x_q       <= vtp_pkg::FIELD_W'(unsigned'(sel[0]));
			out_y_q       <= vtp_pkg::FIELD_W'(unsigned'(sel[1]));
			out_z_q       <= vtp_pkg::FIELD_W'(unsigned'(sel[2]));
			out_w_q       <= vtp_pkg::FIELD_W'(unsigned'(sel[3]));
			was_divided_q <= pass_s[DS-1].use_div;
		end
	end

	assign out_ch.valid       = v_q[NP-1];
	assign out_ch.out_x       = out_x_q;
	assign out_ch.out_y       = out_y_q;
	assign out_ch.out_z       = out_z_q;
	assign out_ch.out_w       = out_w_q;
	assign out_ch.was_divided = was_divided_q;

endmodule

### src/vtp_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_lane
// One matrix row times the vertex: multiply, add tree, >>8, saturate.
// ----------------------------------------------------------------------------
module vtp_lane (
	input  logic                                 clk,
	input  logic [vtp_pkg::LANE_STAGES-1:0]      en,
	input  logic [vtp_pkg::ROW_W-1:0]            row,
	input  vtp_pkg::comp_t                       vec [vtp_pkg::NUM_COMP],
	output vtp_pkg::comp_t                       res
);

	vtp_pkg::coef_t                     coef [vtp_pkg::NUM_COMP];
	logic signed [vtp_pkg::PROD_W-1:0]  prod_s1 [vtp_pkg::NUM_COMP];
	logic signed [vtp_pkg::PROD_W:0]    pair_s2 [2];
	logic signed [vtp_pkg::SUM_W-1:0]   sum;
	logic signed [vtp_pkg::SUM_W-1:0]   shifted;
	vtp_pkg::comp_t                     res_s3;

	always_comb begin
		for (int j = 0; j < vtp_pkg::NUM_COMP; j++) begin
			coef[j] = row[vtp_pkg::COEF_PITCH*j +: vtp_pkg::COEF_WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < vtp_pkg::NUM_COMP; j++) begin
				prod_s1[j] <= vtp_pkg::PROD_W'(vec[j]) * vtp_pkg::PROD_W'(coef[j]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pair_s2[0] <= (vtp_pkg::PROD_W+1)'(prod_s1[0]) + (vtp_pkg::PROD_W+1)'(prod_s1[1]);
			pair_s2[1] <= (vtp_pkg::PROD_W+1)'(prod_s1[2]) + (vtp_pkg::PROD_W+1)'(prod_s1[3]);
		end
	end

	// Q24.24 sum back to Q16.16, floor via arithmetic shift
	always_comb begin
		sum     = vtp_pkg::SUM_W'(pair_s2[0]) + vtp_pkg::SUM_W'(pair_s2[1]);
		shifted = sum >>> vtp_pkg::PROD_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			if (shifted > vtp_pkg::SUM_W'(vtp_pkg::COMP_MAX)) begin
				res_s3 <= vtp_pkg::COMP_MAX;
			end else if (shifted < vtp_pkg::SUM_W'(vtp_pkg::COMP_MIN)) begin
				res_s3 <= vtp_pkg::COMP_MIN;
			end else begin
				res_s3 <= vtp_pkg::COMPONENT_WIDTH'(shifted);
			end
		end
	end

	assign res = res_s3;

endmodule

### src/vtp_div_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtp_div_lane
// Pipelined signed Q16.16 divide (num * 2^16 / den), truncating, saturated.
// Restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module vtp_div_lane (
	input  logic                             clk,
	input  logic [vtp_pkg::DIV_STAGES-1:0]   en,
	input  vtp_pkg::comp_t                   num,
	input  vtp_pkg::comp_t                   den,
	output vtp_pkg::comp_t                   quo
);

	localparam int CW = vtp_pkg::COMPONENT_WIDTH;
	localparam int NI = vtp_pkg::DIV_ITERS;
	localparam int QW = vtp_pkg::QUO_W;

	logic                       neg_sa;
	logic [CW-1:0]              n_sa;
	logic [CW-1:0]              d_sa;

	logic [2*CW-1:0]            scaled_num;
	logic [2*CW-1:0]            sat_limit;
	logic [vtp_pkg::NUM_W-1:0]  num_full;

	logic [CW-1:0]              rem_si [NI+1];
	logic [QW-1:0]              quo_si [NI+1];
	logic [CW-1:0]              n_si   [NI+1];
	logic [CW-1:0]              d_si   [NI+1];
	logic                       neg_si [NI+1];
	logic                       sat_si [NI+1];

	vtp_pkg::comp_t             q_mag;
	vtp_pkg::comp_t             quo_sf;

	// magnitudes and sign
	always_ff @(posedge clk) begin
		if (en[0]) begin
			neg_sa <= num[CW-1] ^ den[CW-1];
			n_sa   <= num[CW-1] ? unsigned'(-num) : unsigned'(num);
			d_sa   <= den[CW-1] ? unsigned'(-den) : unsigned'(den);
		end
	end

	// overflow check and first partial remainder
	always_comb begin
		scaled_num = (2*CW)'(n_sa) << vtp_pkg::FRAC_SHIFT;
		sat_limit  = (2*CW)'(d_sa) << (CW-1);
		num_full   = vtp_pkg::NUM_W'(n_sa) << vtp_pkg::FRAC_SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sat_si[0] <= scaled_num >= sat_limit;
			rem_si[0] <= CW'(num_full >> QW);
			quo_si[0] <= '0;
			n_si[0]   <= n_sa;
			d_si[0]   <= d_sa;
			neg_si[0] <= neg_sa;
		end
	end

	for (genvar k = 0; k < NI; k++) begin : g_iter
		localparam int T_HI = QW - 1 - 2*k;
		localparam int T_LO = QW - 2 - 2*k;

		logic [vtp_pkg::NUM_W-1:0] nn;
		logic [CW:0]               r_a;
		logic [CW:0]               r_b;
		logic [CW-1:0]             rem_mid;
		logic [CW-1:0]             rem_end;
		logic                      b_hi;
		logic                      b_lo;

		always_comb begin
			nn      = vtp_pkg::NUM_W'(n_si[k]) << vtp_pkg::FRAC_SHIFT;
			r_a     = {rem_si[k], nn[T_HI]};
			b_hi    = r_a >= {1'b0, d_si[k]};
			rem_mid = b_hi ? CW'(r_a - {1'b0, d_si[k]}) : CW'(r_a);
			r_b     = {rem_mid, nn[T_LO]};
			b_lo    = r_b >= {1'b0, d_si[k]};
			rem_end = b_lo ? CW'(r_b - {1'b0, d_si[k]}) : CW'(r_b);
		end

		always_ff @(posedge clk) begin
			if (en[2+k]) begin
				rem_si[k+1] <= rem_end;
				quo_si[k+1] <= {quo_si[k][QW-3:0], b_hi, b_lo};
				n_si[k+1]   <= n_si[k];
				d_si[k+1]   <= d_si[k];
				neg_si[k+1] <= neg_si[k];
				sat_si[k+1] <= sat_si[k];
			end
		end
	end

	assign q_mag = CW'(quo_si[NI]);

	always_ff @(posedge clk) begin
		if (en[NI+2]) begin
			if (sat_si[NI]) begin
				quo_sf <= neg_si[NI] ? vtp_pkg::COMP_MIN : vtp_pkg::COMP_MAX;
			end else begin
				quo_sf <= neg_si[NI] ? -q_mag : q_mag;
			end
		end
	end

	assign quo = quo_sf;

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives vertices through the 4x4 transform block under a series of matrix
// and divide settings and scores every result against hand-written values or a
// behavioral model of the Q8.8 x Q16.16 product, saturation and perspective divide.
// ----------------------------------------------------------------------------
module testbench;
	import vtp_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int NUM_PHASES      = 10;
	localparam int ITEMS_PER_PHASE = 173;
	localparam int STEADY_PHASE    = 4;
	localparam int MAX_REPORTS     = 10;
	localparam int STALL_BURST     = 30;

	localparam field_t F_MAX = COMP_MAX;
	localparam field_t F_MIN = COMP_MIN;
	localparam field_t Q_ONE = 32'sd65536;

	typedef logic [NUM_COMP-1:0][ROW_W-1:0] matrix_t;

	typedef struct packed {
		field_t x;
		field_t y;
		field_t z;
		field_t w;
	} vertex_t;

	typedef struct packed {
		field_t x;
		field_t y;
		field_t z;
		field_t w;
		logic   divided;
	} xform_t;

	typedef struct packed {
		matrix_t rows;
		logic    div;
	} setting_t;

	typedef struct {
		int unsigned preset;
		vertex_t     v;
		bit          typed;
		xform_t      want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ROW_W-1:0]     cfg_data;

	vtp_in_if  in_if();
	vtp_out_if out_if();

	vertex_transform_perspective_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	always #2 clk = ~clk;

	// shadow of the block's registers
	matrix_t model_rows;
	logic    model_div;

	xform_t    projected_q[$];
	stim_row_t directed_rows[$];
	setting_t  preset[5];

	// sideband that travels with the item on the input channel
	bit     given_typed;
	xform_t given_want;

	bit no_idle = 1'b0;
	int stall_run = 0;
	int fault_count = 0;
	int result_idx = 0;
	int cycle_count = 0;

	// ------------------------------------------------------------------
	// behavioral model
	// ------------------------------------------------------------------
	function automatic comp_t clamp_comp(longint v);
		if (v > longint'(COMP_MAX))
			return COMP_MAX;
		if (v < longint'(COMP_MIN))
			return COMP_MIN;
		return comp_t'(v);
	endfunction

	function automatic comp_t dot_row(logic [ROW_W-1:0] row, vertex_t v);
		comp_t  comp[NUM_COMP];
		coef_t  c;
		longint acc;
		comp[0] = v.x;
		comp[1] = v.y;
		comp[2] = v.z;
		comp[3] = v.w;
		acc = 0;
		for (int j = 0; j < NUM_COMP; j++) begin
			c = coef_t'(row[j*COEF_PITCH +: COEF_WIDTH]);
			acc += longint'(comp[j]) * longint'(c);
		end
		return clamp_comp(acc >>> PROD_SHIFT);
	endfunction

	// (num << 16) / den, truncated toward zero, saturated
	function automatic comp_t divide_q16(comp_t num, comp_t den);
		longint unsigned n;
		longint unsigned d;
		longint unsigned q;
		longint unsigned lim;
		bit              neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? longint'(-longint'(num)) : longint'(num);
		d = (den < 0) ? longint'(-longint'(den)) : longint'(den);
		q = (n << FRAC_SHIFT) / d;
		lim = 64'd1 << (COMPONENT_WIDTH - 1);
		if (neg) begin
			if (q >= lim)
				return COMP_MIN;
			return comp_t'(-longint'(q));
		end
		if (q >= lim)
			return COMP_MAX;
		return comp_t'(q);
	endfunction

	function automatic xform_t transform_vertex(vertex_t v);
		comp_t  res[NUM_COMP];
		xform_t r;
		for (int i = 0; i < NUM_COMP; i++)
			res[i] = dot_row(model_rows[i], v);
		r.divided = 1'b0;
		if (model_div && res[3] != 0) begin
			for (int i = 0; i < NUM_DIV; i++)
				res[i] = divide_q16(res[i], res[3]);
			r.divided = 1'b1;
		end
		r.x = res[0];
		r.y = res[1];
		r.z = res[2];
		r.w = res[3];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [ROW_W-1:0] pack_coefs(coef_t c0, coef_t c1, coef_t c2, coef_t c3);
		return {c3, c2, c1, c0};
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(3))
			0: return coef_t'($urandom);
			1: return coef_t'(int'($urandom_range(1024)) - 512);
			2: begin
				case ($urandom_range(4))
					0: return coef_t'(16'h7FFF);
					1: return coef_t'(16'h8000);
					2: return coef_t'(0);
					3: return coef_t'(COEF_ONE);
					default: return coef_t'(-COEF_ONE);
				endcase
			end
			default: return coef_t'(COEF_ONE + int'($urandom_range(64)) - 32);
		endcase
	endfunction

	function automatic field_t rand_comp();
		case ($urandom_range(4))
			0: return field_t'(int'($urandom_range(1 << 21)) - (1 << 20));
			1: return field_t'((int'($urandom_range(128)) - 64) * 65536);
			2: begin
				case ($urandom_range(4))
					0: return F_MAX;
					1: return F_MIN;
					2: return field_t'(0);
					3: return field_t'(1);
					default: return field_t'(-1);
				endcase
			end
			default: return field_t'($urandom);
		endcase
	endfunction

	function automatic vertex_t rand_vertex();
		vertex_t v;
		v.x = rand_comp();
		v.y = rand_comp();
		v.z = rand_comp();
		case ($urandom_range(7))
			0: v.w = field_t'(0);
			1, 2: v.w = Q_ONE;
			default: v.w = rand_comp();
		endcase
		return v;
	endfunction

	function automatic setting_t rand_setting(int phase);
		setting_t s;
		for (int i = 0; i < NUM_COMP; i++) begin
			case ($urandom_range(3))
				0: s.rows[i] = ROW_W'(COEF_ONE) << (i * COEF_PITCH);
				3: s.rows[i] = pack_coefs(coef_t'(int'($urandom_range(512)) - 256),
					coef_t'(int'($urandom_range(512)) - 256),
					coef_t'(int'($urandom_range(512)) - 256),
					coef_t'(int'($urandom_range(512)) - 256));
				default: s.rows[i] = pack_coefs(rand_coef(), rand_coef(), rand_coef(),
					rand_coef());
			endcase
		end
		s.div = phase[0];
		return s;
	endfunction

	task automatic add_row(int unsigned p, vertex_t v, bit typed, xform_t want);
		stim_row_t r;
		r.preset = p;
		r.v = v;
		r.typed = typed;
		r.want = want;
		directed_rows.push_back(r);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx <= REG_ROW3)
			model_rows[idx] = data;
		else if (idx == REG_DIV_EN)
			model_div = data[0];
		@(negedge clk);
	endtask

	task automatic load_setting(setting_t s);
		logic [ROW_W-1:0] data;
		// unused indexes first: the block must ignore them
		for (int k = REG_DIV_EN + 1; k < (1 << CFG_IDX_W); k++)
			write_reg(k, {$urandom, $urandom});
		for (int i = 0; i < NUM_COMP; i++)
			write_reg(REG_ROW0 + i, s.rows[i]);
		data = {$urandom, $urandom};
		data[0] = s.div;
		write_reg(REG_DIV_EN, data);
		cfg_we <= 1'b0;
	endtask

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_vertex(vertex_t v, bit typed, xform_t want);
		while (!no_idle && $urandom_range(99) < 8) begin
			in_if.valid <= 1'b0;
			@(negedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.in_x <= v.x;
		in_if.in_y <= v.y;
		in_if.in_z <= v.z;
		in_if.in_w <= v.w;
		given_typed <= typed;
		given_want <= want;
		do
			@(posedge clk);
		while (in_if.ready !== 1'b1);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_if.valid <= 1'b0;
		@(negedge clk);
		while (projected_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// result sink with random stalls
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (stall_run > 0) begin
			out_if.ready <= 1'b0;
			stall_run <= stall_run - 1;
		end else if (!no_idle && $urandom_range(999) == 0) begin
			// long stall lets the pipeline fill and push back on the input
			out_if.ready <= 1'b0;
			stall_run <= STALL_BURST;
		end else begin
			out_if.ready <= no_idle || ($urandom_range(99) >= 5);
		end
	end

	// ------------------------------------------------------------------
	// scoreboard
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		xform_t got;
		xform_t want;
		if (arst_n) begin
			if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
				got = '{out_if.out_x, out_if.out_y, out_if.out_z, out_if.out_w,
					out_if.was_divided};
				if (projected_q.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("result %0d: unexpected item x=%h y=%h z=%h w=%h div=%b",
							result_idx, got.x, got.y, got.z, got.w, got.divided);
				end else begin
					want = projected_q.pop_front();
					if (got !== want) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS) begin
							$display("result %0d: want x=%h y=%h z=%h w=%h div=%b",
								result_idx, want.x, want.y, want.z, want.w, want.divided);
							$display("result %0d:  got x=%h y=%h z=%h w=%h div=%b",
								result_idx, got.x, got.y, got.z, got.w, got.divided);
						end
					end
				end
				result_idx++;
			end
			if (in_if.valid === 1'b1 && in_if.ready === 1'b1) begin
				if (given_typed)
					projected_q.push_back(given_want);
				else
					projected_q.push_back(transform_vertex('{in_if.in_x, in_if.in_y,
						in_if.in_z, in_if.in_w}));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int unsigned active;
		setting_t    s;
		xform_t      none;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_if.valid = 1'b0;
		in_if.in_x = '0;
		in_if.in_y = '0;
		in_if.in_z = '0;
		in_if.in_w = '0;
		out_if.ready = 1'b0;
		given_typed = 1'b0;
		given_want = '0;
		none = '0;

		for (int i = 0; i < NUM_COMP; i++)
			model_rows[i] = ROW_W'(COEF_ONE) << (i * COEF_PITCH);
		model_div = 1'b0;

		// 0: reset state, 1: identity with divide, 2/3: coefficient extremes,
		// 4: a projection-like matrix
		preset[0] = {model_rows, 1'b0};
		preset[1] = {model_rows, 1'b1};
		for (int i = 0; i < NUM_COMP; i++) begin
			preset[2].rows[i] = pack_coefs(coef_t'(16'h8000), coef_t'(16'h8000),
				coef_t'(16'h8000), coef_t'(16'h8000));
			preset[3].rows[i] = pack_coefs(coef_t'(16'h7FFF), coef_t'(16'h7FFF),
				coef_t'(16'h7FFF), coef_t'(16'h7FFF));
		end
		preset[2].div = 1'b1;
		preset[3].div = 1'b0;
		preset[4].rows[0] = pack_coefs(coef_t'(16'h0180), 0, 0, coef_t'(16'h0040));
		preset[4].rows[1] = pack_coefs(0, coef_t'(16'h0200), coef_t'(16'hFF80), 0);
		preset[4].rows[2] = pack_coefs(0, 0, coef_t'(16'hFF00), coef_t'(16'hFE00));
		preset[4].rows[3] = pack_coefs(0, 0, coef_t'(16'hFF00), 0);
		preset[4].div = 1'b1;

		// identity passes the vertex through unchanged
		add_row(0, '{0, 0, 0, 0}, 1, '{0, 0, 0, 0, 1'b0});
		add_row(0, '{F_MAX, F_MIN, F_MAX, F_MIN}, 1, '{F_MAX, F_MIN, F_MAX, F_MIN, 1'b0});
		add_row(0, '{F_MIN, F_MAX, -1, 1}, 1, '{F_MIN, F_MAX, -1, 1, 1'b0});
		add_row(0, '{1, -1, 32'h55555555, 32'hAAAAAAAA}, 1,
			'{1, -1, 32'h55555555, 32'hAAAAAAAA, 1'b0});
		// zero w skips the divide
		add_row(1, '{F_MAX, F_MIN, 12345, 0}, 1, '{F_MAX, F_MIN, 12345, 0, 1'b0});
		add_row(1, '{F_MAX, F_MIN, -Q_ONE, Q_ONE}, 1, '{F_MAX, F_MIN, -Q_ONE, Q_ONE, 1'b1});
		// tiny divisors can saturate the quotient
		add_row(1, '{F_MAX, F_MIN, 0, 1}, 1, '{F_MAX, F_MIN, 0, 1, 1'b1});
		add_row(1, '{1, -1, F_MIN, -1}, 1, '{-Q_ONE, Q_ONE, F_MAX, -1, 1'b1});
		add_row(1, '{F_MIN, 0, Q_ONE, -Q_ONE}, 1, '{F_MAX, 0, -Q_ONE, -Q_ONE, 1'b1});
		add_row(1, '{3 * Q_ONE, -Q_ONE, Q_ONE / 2, 2 * Q_ONE}, 0, none);
		add_row(2, '{F_MAX, F_MAX, F_MAX, F_MAX}, 0, none);
		add_row(2, '{F_MIN, F_MIN, F_MIN, F_MIN}, 0, none);
		add_row(2, '{F_MAX, F_MIN, F_MAX, F_MIN}, 0, none);
		add_row(2, '{1, 0, 0, 0}, 0, none);
		add_row(3, '{F_MAX, F_MAX, F_MAX, F_MAX}, 0, none);
		add_row(3, '{F_MIN, F_MIN, F_MIN, F_MIN}, 0, none);
		add_row(3, '{Q_ONE, -1, 0, Q_ONE}, 0, none);
		add_row(4, '{Q_ONE, 2 * Q_ONE, -5 * Q_ONE, Q_ONE}, 0, none);
		add_row(4, '{-7 * Q_ONE, 3 * Q_ONE, 10 * Q_ONE, Q_ONE}, 0, none);
		add_row(4, '{0, 0, 0, Q_ONE}, 0, none);
		add_row(4, '{123456, -654321, -Q_ONE / 4, Q_ONE}, 0, none);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		active = 0;
		foreach (directed_rows[i]) begin
			if (directed_rows[i].preset != active) begin
				drain_results();
				load_setting(preset[directed_rows[i].preset]);
				active = directed_rows[i].preset;
			end
			send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);
		end

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			s = rand_setting(phase);
			load_setting(s);
			no_idle = (phase == STEADY_PHASE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_vertex(rand_vertex(), 0, none);
		end
		no_idle = 1'b0;

		drain_results();
		repeat (2 * PIPE_STAGES) @(negedge clk);
		if (fault_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
src/vtp_pkg.sv
src/vtp_in_if.sv
src/vtp_out_if.sv
src/vtp_lane.sv
src/vtp_div_lane.sv
src/vertex_transform_perspective_core.sv
test/testbench.sv
